### hdl/obb_pkg.sv
// Package for the oriented box overlap tester: pipeline stage indexes,
// configuration register indexes and the lane-to-merge result type.
// No dependencies.
package obb_pkg;

  // Pipeline stages: corners/edges, products, dot sums, upper bound,
  // interval compares, merged output register
  localparam int NUM_STAGES = 6;
  localparam int STG_EDGE   = 0;
  localparam int STG_MUL    = 1;
  localparam int STG_DOT    = 2;
  localparam int STG_BOUND  = 3;
  localparam int STG_CMP    = 4;
  localparam int STG_OUT    = 5;

  localparam int NUM_LANES   = 4;
  localparam int NUM_CORNERS = 4;

  // Configuration register indexes
  localparam int CFG_AW   = 3;
  localparam int NUM_REGS = 8;
  localparam logic [CFG_AW-1:0] REG_C0_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_C0_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_C1_X = 3'd2;
  localparam logic [CFG_AW-1:0] REG_C1_Y = 3'd3;
  localparam logic [CFG_AW-1:0] REG_C2_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_C2_Y = 3'd5;
  localparam logic [CFG_AW-1:0] REG_C3_X = 3'd6;
  localparam logic [CFG_AW-1:0] REG_C3_Y = 3'd7;

  // Per-stage load enables from the top-level flow control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

  // What one axis lane found for one transaction
  typedef struct packed {
    logic [NUM_CORNERS-1:0] above_hi;  // projection beyond far end of axis span
    logic [NUM_CORNERS-1:0] below_lo;  // projection before near end of axis span
    logic                   zero_edge; // axis edge has zero length
  } lane_res_t;

endpackage

### hdl/obb_lane.sv
// One separating-axis lane: builds an edge axis of one box, projects the
// other box's four corners on it and compares against the box's own span.
// Depends on obb_pkg.
module obb_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                      clk,
  input  obb_pkg::pipe_ctl_t                        ctl,
  input  logic [COORD_WIDTH-1:0]                    a0_x,
  input  logic [COORD_WIDTH-1:0]                    a0_y,
  input  logic [COORD_WIDTH-1:0]                    a1_x,
  input  logic [COORD_WIDTH-1:0]                    a1_y,
  input  logic [obb_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] o_x,
  input  logic [obb_pkg::NUM_CORNERS-1:0][COORD_WIDTH-1:0] o_y,
  output obb_pkg::lane_res_t                        res
);

  localparam int W  = COORD_WIDTH;
  localparam int EW = W + 1;       // edge vector component
  localparam int PW = 2 * EW;      // single product
  localparam int DW = 2 * W + 4;   // dot products and span bounds
  localparam int NC = obb_pkg::NUM_CORNERS;

  // ---------------- stage: edge vector and corner capture
  logic signed [EW-1:0] ex_nxt, ey_nxt;
  logic                 zero_nxt;
  logic signed [EW-1:0] ax_r, ay_r, ex_r, ey_r;
  logic signed [NC-1:0][EW-1:0] ox_r, oy_r;
  logic                 zero_a_r;

  always_comb begin
    ex_nxt   = $signed({a1_x[W-1], a1_x}) - $signed({a0_x[W-1], a0_x});
    ey_nxt   = $signed({a1_y[W-1], a1_y}) - $signed({a0_y[W-1], a0_y});
    zero_nxt = (a1_x == a0_x) && (a1_y == a0_y);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_EDGE]) begin
      ax_r     <= {a0_x[W-1], a0_x};
      ay_r     <= {a0_y[W-1], a0_y};
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
      zero_a_r <= zero_nxt;
      for (int c = 0; c < NC; c++) begin
        ox_r[c] <= {o_x[c][W-1], o_x[c]};
        oy_r[c] <= {o_y[c][W-1], o_y[c]};
      end
    end
  end

  // ---------------- stage: products
  logic signed [PW-1:0] pax_r, pay_r, sqx_r, sqy_r;
  logic signed [NC-1:0][PW-1:0] ptx_r, pty_r;
  logic                 zero_b_r;

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_MUL]) begin
      pax_r    <= ax_r * ex_r;
      pay_r    <= ay_r * ey_r;
      sqx_r    <= ex_r * ex_r;
      sqy_r    <= ey_r * ey_r;
      zero_b_r <= zero_a_r;
      // element selects of a packed array are unsigned, so recast them
      for (int c = 0; c < NC; c++) begin
        ptx_r[c] <= $signed(ox_r[c]) * ex_r;
        pty_r[c] <= $signed(oy_r[c]) * ey_r;
      end
    end
  end

  // ---------------- stage: dot sums (span start, |e|^2, projections)
  logic signed [DW-1:0] lo_nxt, sq_nxt;
  logic signed [NC-1:0][DW-1:0] t_nxt;
  logic signed [DW-1:0] lo_r, sq_r;
  logic signed [NC-1:0][DW-1:0] t_r;
  logic                 zero_c_r;

  always_comb begin
    lo_nxt = $signed({{(DW-PW){pax_r[PW-1]}}, pax_r})
           + $signed({{(DW-PW){pay_r[PW-1]}}, pay_r});
    sq_nxt = $signed({{(DW-PW){sqx_r[PW-1]}}, sqx_r})
           + $signed({{(DW-PW){sqy_r[PW-1]}}, sqy_r});
    for (int c = 0; c < NC; c++) begin
      t_nxt[c] = $signed({{(DW-PW){ptx_r[c][PW-1]}}, ptx_r[c]})
               + $signed({{(DW-PW){pty_r[c][PW-1]}}, pty_r[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_DOT]) begin
      lo_r     <= lo_nxt;
      sq_r     <= sq_nxt;
      t_r      <= t_nxt;
      zero_c_r <= zero_b_r;
    end
  end

  // ---------------- stage: span end
  logic signed [DW-1:0] hi_nxt;
  logic signed [DW-1:0] lo_d_r, hi_r;
  logic signed [NC-1:0][DW-1:0] t_d_r;
  logic                 zero_d_r;

  assign hi_nxt = lo_r + sq_r;

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_BOUND]) begin
      lo_d_r   <= lo_r;
      hi_r     <= hi_nxt;
      t_d_r    <= t_r;
      zero_d_r <= zero_c_r;
    end
  end

  // ---------------- stage: interval compares, one per corner and end
  obb_pkg::lane_res_t res_nxt;
  obb_pkg::lane_res_t res_r;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      res_nxt.above_hi[c] = $signed(t_d_r[c]) > hi_r;
      res_nxt.below_lo[c] = $signed(t_d_r[c]) < lo_d_r;
    end
    res_nxt.zero_edge = zero_d_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_CMP]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### hdl/obb_merge.sv
// Merge stage: combines the four axis lanes into the overlap and
// degenerate flags and holds them in the output register.
// Depends on obb_pkg.
module obb_merge (
  input  logic                                         clk,
  input  obb_pkg::pipe_ctl_t                           ctl,
  input  obb_pkg::lane_res_t [obb_pkg::NUM_LANES-1:0]  lane_res,
  output logic                                         overlap,
  output logic                                         degenerate
);

  logic [obb_pkg::NUM_LANES-1:0] sep;
  logic                          deg_nxt, overlap_nxt;
  logic                          deg_r, overlap_r;

  // An axis separates when every projected corner lies on one side of its span
  always_comb begin
    deg_nxt = 1'b0;
    for (int l = 0; l < obb_pkg::NUM_LANES; l++) begin
      sep[l]  = (&lane_res[l].above_hi) | (&lane_res[l].below_lo);
      deg_nxt = deg_nxt | lane_res[l].zero_edge;
    end
    overlap_nxt = !deg_nxt && !(|sep);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[obb_pkg::STG_OUT]) begin
      overlap_r <= overlap_nxt;
      deg_r     <= deg_nxt;
    end
  end

  assign overlap    = overlap_r;
  assign degenerate = deg_r;

endmodule

### hdl/obb_overlap_test_top.sv
// An accepted transaction passes through the five-register lane pipeline
// (edge, multiply, dot sum, span end, compare) and the merge register on its way
// to out_valid; one transaction per cycle is sustained while out_ready stays high.
// Each stage advances independently, so input is taken while a result
// waits as long as some stage is empty. Reset (synchronous, rst_n low)
// empties the pipeline and clears the reference corners to 0.
module obb_overlap_test_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [obb_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [COORD_WIDTH-1:0]             cfg_wdata,
  // candidate box channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c0_x,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c0_y,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c1_x,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c1_y,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c2_x,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c2_y,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c3_x,
  input  logic signed [COORD_WIDTH-1:0]      in_cand_c3_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_overlap,
  output logic                               out_degenerate
);

  localparam int W  = COORD_WIDTH;
  localparam int NS = obb_pkg::NUM_STAGES;
  localparam int NC = obb_pkg::NUM_CORNERS;

  // ---------------- reference box registers
  logic [obb_pkg::NUM_REGS-1:0][W-1:0] ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cfg_we) begin
      ref_r[cfg_addr] <= cfg_wdata;
    end
  end

  // ---------------- per-stage flow control
  logic [NS-1:0]      vld_r, vld_nxt;
  obb_pkg::pipe_ctl_t ctl;

  always_comb begin
    ctl.en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ctl.en[k] = !vld_r[k] || ctl.en[k+1];
    end
    vld_nxt[0] = ctl.en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = ctl.en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = ctl.en[0];
  assign out_valid = vld_r[NS-1];

  // ---------------- corner bundles
  logic [NC-1:0][W-1:0] cand_x, cand_y, refb_x, refb_y;

  assign cand_x = {in_cand_c3_x, in_cand_c2_x, in_cand_c1_x, in_cand_c0_x};
  assign cand_y = {in_cand_c3_y, in_cand_c2_y, in_cand_c1_y, in_cand_c0_y};
  assign refb_x = {ref_r[obb_pkg::REG_C3_X], ref_r[obb_pkg::REG_C2_X],
                   ref_r[obb_pkg::REG_C1_X], ref_r[obb_pkg::REG_C0_X]};
  assign refb_y = {ref_r[obb_pkg::REG_C3_Y], ref_r[obb_pkg::REG_C2_Y],
                   ref_r[obb_pkg::REG_C1_Y], ref_r[obb_pkg::REG_C0_Y]};

  // ---------------- axis lanes: two reference edges, two candidate edges
  obb_pkg::lane_res_t [obb_pkg::NUM_LANES-1:0] lane_res;

  obb_lane #(.COORD_WIDTH(W)) u_lane_ref_e0 (
    .clk (clk), .ctl (ctl),
    .a0_x (refb_x[0]), .a0_y (refb_y[0]), .a1_x (refb_x[1]), .a1_y (refb_y[1]),
    .o_x (cand_x), .o_y (cand_y), .res (lane_res[0])
  );

  obb_lane #(.COORD_WIDTH(W)) u_lane_ref_e1 (
    .clk (clk), .ctl (ctl),
    .a0_x (refb_x[0]), .a0_y (refb_y[0]), .a1_x (refb_x[3]), .a1_y (refb_y[3]),
    .o_x (cand_x), .o_y (cand_y), .res (lane_res[1])
  );

  obb_lane #(.COORD_WIDTH(W)) u_lane_cand_e0 (
    .clk (clk), .ctl (ctl),
    .a0_x (cand_x[0]), .a0_y (cand_y[0]), .a1_x (cand_x[1]), .a1_y (cand_y[1]),
    .o_x (refb_x), .o_y (refb_y), .res (lane_res[2])
  );

  obb_lane #(.COORD_WIDTH(W)) u_lane_cand_e1 (
    .clk (clk), .ctl (ctl),
    .a0_x (cand_x[0]), .a0_y (cand_y[0]), .a1_x (cand_x[3]), .a1_y (cand_y[3]),
    .o_x (refb_x), .o_y (refb_y), .res (lane_res[3])
  );

  // ---------------- merge and output register
  obb_merge u_merge (
    .clk        (clk),
    .ctl        (ctl),
    .lane_res   (lane_res),
    .overlap    (out_overlap),
    .degenerate (out_degenerate)
  );

  // ---------------- assertions
  // the first stage only holds back when it is occupied
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.en[0] |-> vld_r[0])
    else $error("first stage stalled while empty");

  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted transaction lost at pipeline entry");

  // a degenerate box never reports overlap
  a_deg_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overlap && out_degenerate))
    else $error("overlap reported for degenerate box");

  // an output left waiting is not replaced
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_overlap)
                                   && $stable(out_degenerate)))
    else $error("waiting result changed");

endmodule

### dv/tb_obb_overlap_test_top.sv
// Self-checking testbench for obb_overlap_test_top: candidate boxes are tested
// against several reference boxes, with random idling and a long output stall.
// Depends on obb_pkg and obb_overlap_test_top.
module tb_obb_overlap_test_top;

  localparam int CW        = 16;
  localparam int LONG_HOLD = 60;
  localparam int CMAX      = 32767;
  localparam int CMIN      = -32768;

  typedef logic [CW-1:0] coord_t;
  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } box_t;
  typedef struct packed {
    logic overlap;
    logic degenerate;
  } verdict_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [obb_pkg::CFG_AW-1:0] cfg_addr;
  coord_t           cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  box_t             in_box;
  logic             out_valid;
  logic             out_ready;
  logic             out_overlap;
  logic             out_degenerate;

  box_t     target_box;          // reference box as the block should hold it
  verdict_t pending_verdicts[$];
  int       mismatches;
  bit       idling_on;
  int       hold_seq;

  obb_overlap_test_top #(.COORD_WIDTH(CW)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cand_c0_x   (in_box.x[0]),
    .in_cand_c0_y   (in_box.y[0]),
    .in_cand_c1_x   (in_box.x[1]),
    .in_cand_c1_y   (in_box.y[1]),
    .in_cand_c2_x   (in_box.x[2]),
    .in_cand_c2_y   (in_box.y[2]),
    .in_cand_c3_x   (in_box.x[3]),
    .in_cand_c3_y   (in_box.y[3]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_overlap    (out_overlap),
    .out_degenerate (out_degenerate)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint px(box_t b, int i);
    return longint'($signed(b.x[i]));
  endfunction

  function automatic longint py(box_t b, int i);
    return longint'($signed(b.y[i]));
  endfunction

  function automatic bit has_zero_edge(box_t b);
    return (b.x[1] == b.x[0] && b.y[1] == b.y[0]) ||
           (b.x[3] == b.x[0] && b.y[3] == b.y[0]);
  endfunction

  // True when neither edge axis of a separates o from a. Dots are scaled by
  // |e|^2 so the span of a on axis e is [dot(c0,e), dot(c0,e) + |e|^2].
  function automatic bit spans_meet(box_t a, box_t o);
    longint ex, ey, span_lo, span_hi, p, pmin, pmax;
    int     idx;
    for (int k = 0; k < 2; k++) begin
      idx     = (k == 0) ? 1 : 3;
      ex      = px(a, idx) - px(a, 0);
      ey      = py(a, idx) - py(a, 0);
      span_lo = px(a, 0) * ex + py(a, 0) * ey;
      span_hi = span_lo + ex * ex + ey * ey;
      pmin    = px(o, 0) * ex + py(o, 0) * ey;
      pmax    = pmin;
      for (int c = 1; c < 4; c++) begin
        p = px(o, c) * ex + py(o, c) * ey;
        if (p < pmin) pmin = p;
        if (p > pmax) pmax = p;
      end
      if (pmin > span_hi || pmax < span_lo) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(box_t cand);
    verdict_t v;
    v.degenerate = has_zero_edge(target_box) || has_zero_edge(cand);
    v.overlap    = !v.degenerate && spans_meet(target_box, cand) &&
                   spans_meet(cand, target_box);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR t=%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transaction with no expectation waiting");
      end else begin
        want = pending_verdicts.pop_front();
        if (out_overlap !== want.overlap)
          report_mismatch($sformatf("overlap got %b want %b", out_overlap, want.overlap));
        if (out_degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate got %b want %b",
                                    out_degenerate, want.degenerate));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_seq moves
  initial begin
    int seen;
    seen      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen) begin
        seen      = hold_seq;
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_ready = !(idling_on && $urandom_range(0, 99) < 32);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all entered and left just after a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_box(box_t b);
    while (idling_on && $urandom_range(0, 99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_box   = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(b));
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain;
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [obb_pkg::CFG_AW-1:0] idx, coord_t val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    case (idx)
      obb_pkg::REG_C0_X: target_box.x[0] = val;
      obb_pkg::REG_C0_Y: target_box.y[0] = val;
      obb_pkg::REG_C1_X: target_box.x[1] = val;
      obb_pkg::REG_C1_Y: target_box.y[1] = val;
      obb_pkg::REG_C2_X: target_box.x[2] = val;
      obb_pkg::REG_C2_Y: target_box.y[2] = val;
      obb_pkg::REG_C3_X: target_box.x[3] = val;
      obb_pkg::REG_C3_Y: target_box.y[3] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_target(box_t b);
    drain();
    write_reg(obb_pkg::REG_C0_X, b.x[0]);
    write_reg(obb_pkg::REG_C0_Y, b.y[0]);
    write_reg(obb_pkg::REG_C1_X, b.x[1]);
    write_reg(obb_pkg::REG_C1_Y, b.y[1]);
    write_reg(obb_pkg::REG_C2_X, b.x[2]);
    write_reg(obb_pkg::REG_C2_Y, b.y[2]);
    write_reg(obb_pkg::REG_C3_X, b.x[3]);
    write_reg(obb_pkg::REG_C3_Y, b.y[3]);
  endtask

  // ---------------------------------------------------------------------------
  // Box generators
  // ---------------------------------------------------------------------------
  function automatic box_t corners(int x0, int y0, int x1, int y1,
                                   int x2, int y2, int x3, int y3);
    box_t b;
    b.x[0] = coord_t'(x0); b.y[0] = coord_t'(y0);
    b.x[1] = coord_t'(x1); b.y[1] = coord_t'(y1);
    b.x[2] = coord_t'(x2); b.y[2] = coord_t'(y2);
    b.x[3] = coord_t'(x3); b.y[3] = coord_t'(y3);
    return b;
  endfunction

  function automatic int srand(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Rotated rectangle around (cx, cy); coordinates wrap at 16 bits
  function automatic box_t rect_at(int cx, int cy, int size);
    int ux, uy, vx, vy, f, x0, y0;
    ux = srand(size);
    uy = srand(size);
    f  = $urandom_range(1, 3);
    vx = -uy * f / 2;
    vy =  ux * f / 2;
    x0 = cx - ux - vx;
    y0 = cy - uy - vy;
    return corners(x0, y0, x0 + 2 * ux, y0 + 2 * uy,
                   x0 + 2 * ux + 2 * vx, y0 + 2 * uy + 2 * vy,
                   x0 + 2 * vx, y0 + 2 * vy);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return coord_t'(CMIN);
      1: return coord_t'(CMAX);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // One random candidate; mostly well-formed boxes close to the reference
  function automatic box_t random_candidate(int reach, int size);
    box_t   b;
    coord_t t;
    int     sel, cx, cy;
    sel = $urandom_range(0, 99);
    cx  = int'(px(target_box, 0)) + srand(reach);
    cy  = int'(py(target_box, 0)) + srand(reach);
    if (sel < 60) begin
      b = rect_at(cx, cy, size);
      // corners out of order now and then
      if ($urandom_range(0, 9) == 0) begin
        t = b.x[1]; b.x[1] = b.x[2]; b.x[2] = t;
        t = b.y[1]; b.y[1] = b.y[2]; b.y[2] = t;
      end
    end else if (sel < 75) begin
      b = rect_at(cx, cy, size);
      if ($urandom_range(0, 1)) begin
        b.x[1] = b.x[0]; b.y[1] = b.y[0];
      end else begin
        b.x[3] = b.x[0]; b.y[3] = b.y[0];
      end
    end else if (sel < 90) begin
      for (int i = 0; i < 4; i++) begin
        b.x[i] = coord_t'($urandom());
        b.y[i] = coord_t'($urandom());
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        b.x[i] = pick_extreme();
        b.y[i] = pick_extreme();
      end
    end
    return b;
  endfunction

  task automatic random_batch(int count, int reach, int size);
    for (int n = 0; n < count; n++) send_box(random_candidate(reach, size));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reference is all zero after reset, so every result is degenerate
  task automatic test_reset_target;
    send_box(corners(0, 0, 10, 0, 10, 10, 0, 10));
    send_box(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send_box(corners(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_directed_cases;
    load_target(corners(0, 0, 100, 0, 100, 100, 0, 100));
    send_box(corners(10, 10, 90, 10, 90, 90, 10, 90));           // inside
    send_box(corners(-50, -50, 150, -50, 150, 150, -50, 150));   // encloses
    send_box(corners(100, 0, 200, 0, 200, 100, 100, 100));       // shares an edge
    send_box(corners(101, 0, 200, 0, 200, 100, 101, 100));       // one unit apart
    send_box(corners(100, 100, 200, 100, 200, 200, 100, 200));   // corner touch
    send_box(corners(120, 95, 145, 120, 120, 145, 95, 120));     // split by own axis only
    send_box(corners(110, 85, 135, 110, 110, 135, 85, 110));     // diamond overlapping
    send_box(corners(10, 10, 10, 10, 90, 90, 10, 90));           // c1 on c0
    send_box(corners(10, 10, 90, 10, 90, 90, 10, 10));           // c3 on c0
    send_box(corners(10, 10, 90, 90, 90, 10, 10, 90));           // unordered corners
    send_box(corners(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_box(corners(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_box(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send_box(corners(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
    send_box(corners(CMIN, CMIN, -32000, CMIN, -32000, -32000, CMIN, -32000));

    // full-range reference: largest products and spans
    load_target(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send_box(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    send_box(corners(CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN));
    send_box(corners(0, 0, 1, 0, 1, 1, 0, 1));
    send_box(corners(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));

    // reference with a zero-length edge
    load_target(corners(5, 5, 5, 5, 50, 50, 5, 50));
    send_box(corners(10, 10, 90, 10, 90, 90, 10, 90));
    send_box(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
  endtask

  // Several reference settings, each with a batch of random candidates
  task automatic test_random_targets;
    box_t b;
    load_target(rect_at(srand(20000), srand(20000), 3000));
    random_batch(250, 8000, 3000);

    // near the positive corner of the range, no idling on either side
    idling_on = 1'b0;
    load_target(corners(CMAX, CMAX, CMAX - 4000, CMAX - 1000,
                        CMAX - 5000, CMAX - 5000 + 4000 - 1000, CMAX - 1000, CMAX - 4000));
    random_batch(200, 6000, 4000);
    idling_on = 1'b1;

    load_target(corners(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX));
    random_batch(200, 40000, 16000);

    // small tilted square: many touching and near-miss cases
    load_target(corners(0, 0, 3, 1, 2, 4, -1, 3));
    random_batch(250, 6, 3);

    b = rect_at(srand(1000), srand(1000), 500);
    b.x[3] = b.x[0];
    b.y[3] = b.y[0];
    load_target(b);
    random_batch(50, 1000, 500);

    load_target(rect_at(srand(30000), srand(30000), 8000));
    random_batch(250, 16000, 8000);
  endtask

  // Output held off while input keeps coming, so the pipeline fills and stalls
  task automatic test_backpressure;
    load_target(corners(0, 0, 100, 0, 100, 100, 0, 100));
    idling_on = 1'b0;
    hold_seq++;
    random_batch(30, 200, 80);
    idling_on = 1'b1;
    random_batch(20, 200, 80);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = obb_pkg::REG_C0_X;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_box     = '0;
    target_box = '0;
    mismatches = 0;
    idling_on  = 1'b1;
    hold_seq   = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_target();
    test_directed_cases();
    test_random_targets();
    test_backpressure();

    drain();
    repeat (4 * obb_pkg::NUM_STAGES) @(negedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
